/* rtl/olsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olsd_pkg
// Shared types and codes for the ordered list search/delete block.
// ----------------------------------------------------------------------------
package olsd_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 16;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned REQ_W          = 2;
  localparam int unsigned STAT_W         = 2;
  localparam int unsigned POS_OUT_W      = 4;
  localparam int unsigned CNT_OUT_W      = 5;

  // request codes
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  // per-cell control from the sequencer
  typedef struct packed {
    logic start;    // load token into the head cell, clear passed marks
    logic advance;  // token moves one cell toward the tail
    logic shift;    // cells at or past the token take the next cell's value
    logic write;    // this cell takes the appended value
  } cell_ctrl_t;

endpackage

/* rtl/ordered_list_search_delete_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_search_delete_top
// Bounded ordered list of signed words with append, search and delete.
// ----------------------------------------------------------------------------
// The list sits in a row of LIST_DEPTH cells. Append, an unknown request and
// a search or delete on an empty list finish in the accept cycle; the result
// word is registered and shows in the cycle after, and the next word may be
// accepted right after. Search and delete walk a token down the cells one
// cell per cycle, ending on the first match or at the last entry; on delete
// the gap closes in the cycle the match is seen, every later cell taking its
// neighbor's value at once. A new word is held off while a result waits to
// be taken; it may enter in the cycle that result is taken.
// ----------------------------------------------------------------------------
module ordered_list_search_delete_top #(
  parameter int unsigned LIST_DEPTH = olsd_pkg::LIST_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [olsd_pkg::REQ_W-1:0]            req_type_i,
  input  logic signed [olsd_pkg::VALUE_W-1:0]   item_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [olsd_pkg::STAT_W-1:0]           status_o,
  output logic                                  found_o,
  output logic [olsd_pkg::POS_OUT_W-1:0]        match_position_o,
  output logic [olsd_pkg::CNT_OUT_W-1:0]        entry_count_o
);
  import olsd_pkg::*;

  localparam int unsigned IW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e          state_q, state_d;
  logic [IW-1:0]   pos_q, pos_d;
  logic [CW-1:0]   count_q, count_d;
  logic            del_q, del_d;
  logic signed [VALUE_W-1:0] key_q;
  logic            out_valid_q, out_valid_d;

  logic [STAT_W-1:0] res_status_q, res_status_d;
  logic              res_found_q, res_found_d;
  logic [IW-1:0]     res_pos_q, res_pos_d;
  logic [CW-1:0]     res_count_q;
  logic              res_load;

  logic in_acc, out_free;
  logic is_app, is_find, full, empty, last, any_hit;
  logic scan_hit, advance, shift;

  logic [LIST_DEPTH-1:0]   tok_vec, hit_vec;
  logic signed [VALUE_W-1:0] val_vec [LIST_DEPTH];
  cell_ctrl_t              ctrl_vec [LIST_DEPTH];

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign is_app  = (req_type_i == REQ_APPEND);
  assign is_find = (req_type_i == REQ_SEARCH) || (req_type_i == REQ_DELETE);
  assign full    = (count_q == CW'(LIST_DEPTH));
  assign empty   = (count_q == '0);
  assign last    = ((CW'(pos_q) + CW'(1)) == count_q);
  assign any_hit = |hit_vec;

  assign scan_hit = (state_q == S_SCAN) && any_hit;
  assign advance  = (state_q == S_SCAN) && !any_hit && !last;
  assign shift    = scan_hit && del_q;

  // cell row
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic                      tok_in;
    logic signed [VALUE_W-1:0] nxt_val;

    if (i == 0) begin : g_head
      assign tok_in = 1'b0;
    end else begin : g_body
      assign tok_in = tok_vec[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_tail
      assign nxt_val = val_vec[i];
    end else begin : g_mid
      assign nxt_val = val_vec[i+1];
    end

    assign ctrl_vec[i].start   = in_acc && is_find && !empty;
    assign ctrl_vec[i].advance = advance;
    assign ctrl_vec[i].shift   = shift;
    assign ctrl_vec[i].write   = in_acc && is_app && (count_q == CW'(i));

    olsd_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_vec[i]),
      .key_i        (key_q),
      .wr_value_i   (item_value_i),
      .next_value_i (nxt_val),
      .tok_i        (tok_in),
      .value_o      (val_vec[i]),
      .tok_o        (tok_vec[i]),
      .hit_o        (hit_vec[i])
    );
  end

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    count_d      = count_q;
    del_d        = del_q;
    out_valid_d  = out_valid_q && out_stall_i;
    res_load     = 1'b0;
    res_status_d = STAT_OK;
    res_found_d  = 1'b0;
    res_pos_d    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (is_app) begin
            res_load = 1'b1;
            if (full) begin
              res_status_d = STAT_FULL;
            end else begin
              count_d = count_q + CW'(1);
            end
          end else if (is_find) begin
            if (empty) begin
              res_load     = 1'b1;
              res_status_d = STAT_NOT_FOUND;
            end else begin
              state_d = S_SCAN;
              pos_d   = '0;
              del_d   = (req_type_i == REQ_DELETE);
            end
          end else begin
            res_load = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (any_hit) begin
          res_load    = 1'b1;
          res_found_d = 1'b1;
          res_pos_d   = pos_q;
          state_d     = S_IDLE;
          if (del_q) begin
            count_d = count_q - CW'(1);
          end
        end else if (last) begin
          res_load     = 1'b1;
          res_status_d = STAT_NOT_FOUND;
          state_d      = S_IDLE;
        end else begin
          pos_d = pos_q + IW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      count_q     <= '0;
      del_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      del_q       <= del_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q <= item_value_i;
    end
    if (res_load) begin
      res_status_q <= res_status_d;
      res_found_q  <= res_found_d;
      res_pos_q    <= res_pos_d;
      res_count_q  <= count_d;
    end
  end

  // widen before masking so narrow depths still map cleanly
  logic [IW+POS_OUT_W-1:0] pos_wide;
  logic [CW+CNT_OUT_W-1:0] cnt_wide;
  assign pos_wide = {{POS_OUT_W{1'b0}}, res_pos_q};
  assign cnt_wide = {{CNT_OUT_W{1'b0}}, res_count_q};

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_status_q;
  assign found_o          = res_found_q;
  assign match_position_o = pos_wide[POS_OUT_W-1:0];
  assign entry_count_o    = cnt_wide[CNT_OUT_W-1:0];

  // token is a single walker, always present while scanning
  a_tok_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec)) else $error("more than one scan token");

  a_scan_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> $onehot(tok_vec)) else $error("scan without token");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(LIST_DEPTH)) else $error("entry count beyond depth");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_found_q) |-> (res_status_q == STAT_OK))
    else $error("found word with bad status");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !res_load)
    else $error("result register overwritten while stalled");

endmodule

/* rtl/olsd_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olsd_cell
// One list slot: holds a value, carries the scan token, closes the gap on
// delete by taking its tail-side neighbor's value.
// ----------------------------------------------------------------------------
module olsd_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  olsd_pkg::cell_ctrl_t                ctrl_i,
  input  logic signed [olsd_pkg::VALUE_W-1:0] key_i,
  input  logic signed [olsd_pkg::VALUE_W-1:0] wr_value_i,
  input  logic signed [olsd_pkg::VALUE_W-1:0] next_value_i,
  input  logic                                tok_i,
  output logic signed [olsd_pkg::VALUE_W-1:0] value_o,
  output logic                                tok_o,
  output logic                                hit_o
);
  import olsd_pkg::*;

  logic signed [VALUE_W-1:0] value_q;
  logic                      token_q;
  logic                      passed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q  <= 1'b0;
      passed_q <= 1'b0;
    end else if (ctrl_i.start) begin
      token_q  <= (IDX == 0);
      passed_q <= 1'b0;
    end else if (ctrl_i.advance) begin
      token_q <= tok_i;
      if (token_q) begin
        passed_q <= 1'b1;
      end
    end else if (ctrl_i.shift) begin
      token_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write) begin
      value_q <= wr_value_i;
    end else if (ctrl_i.shift && !passed_q) begin
      value_q <= next_value_i;
    end
  end

  assign value_o = value_q;
  assign tok_o   = token_q;
  assign hit_o   = token_q && (value_q == key_i);

endmodule

/* sim/tb_ordered_list_search_delete_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_search_delete_top
// Self-checking bench for the ordered list block: a directed table covering
// empty, full, duplicate and extreme-value cases, then random append, search
// and delete traffic; words are checked against the table row or a behavioral list.
// ----------------------------------------------------------------------------
module tb_ordered_list_search_delete_top;
  import olsd_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;
  localparam int               DIR_ROWS    = 25;
  localparam int               RAND_WORDS  = 1200;
  localparam int               CYCLE_LIMIT = 600000;
  localparam int               HOLD_CYCLES = 250;
  localparam int               TAIL_CYCLES = 40;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic                 found;
    logic [POS_OUT_W-1:0] pos;
    logic [CNT_OUT_W-1:0] cnt;
  } list_result_t;

  typedef struct {
    logic [REQ_W-1:0]   kind;
    logic [VALUE_W-1:0] value;
    bit                 typed;
    list_result_t       want;
  } dir_row_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_stall_o;
  logic [REQ_W-1:0]            req_type_i   = REQ_APPEND;
  logic signed [VALUE_W-1:0]   item_value_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i  = 1'b0;
  logic [STAT_W-1:0]           status_o;
  logic                        found_o;
  logic [POS_OUT_W-1:0]        match_position_o;
  logic [CNT_OUT_W-1:0]        entry_count_o;

  // fixed expectation riding along with the current word (directed table)
  bit                          want_typed   = 1'b0;
  list_result_t                want_fixed   = '0;

  logic [VALUE_W-1:0]          list_words[LIST_DEPTH_DEF];
  int                          list_len     = 0;
  logic [VALUE_W-1:0]          value_pool[8];
  list_result_t                pending_results[$];
  dir_row_t                    dir_rows[DIR_ROWS];
  int                          err_cnt      = 0;
  int                          cycle_cnt    = 0;
  bit                          hold_go      = 1'b0;

  ordered_list_search_delete_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .item_value_i     (item_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .found_o          (found_o),
    .match_position_o (match_position_o),
    .entry_count_o    (entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // behavioral list: applies one request, returns the word it should produce
  function automatic list_result_t apply_request(input logic [REQ_W-1:0] kind,
                                                 input logic [VALUE_W-1:0] key);
    list_result_t res;
    int           hit_at;
    res    = '0;
    res.status = STAT_OK;
    hit_at = -1;
    if (kind == REQ_APPEND) begin
      if (list_len >= LIST_DEPTH_DEF) begin
        res.status = STAT_FULL;
      end else begin
        list_words[list_len] = key;
        list_len++;
      end
    end else if (kind == REQ_SEARCH || kind == REQ_DELETE) begin
      for (int i = 0; i < list_len; i++) begin
        if (hit_at < 0 && list_words[i] == key) hit_at = i;
      end
      if (hit_at < 0) begin
        res.status = STAT_NOT_FOUND;
      end else begin
        res.found = 1'b1;
        res.pos   = POS_OUT_W'(hit_at);
        if (kind == REQ_DELETE) begin
          for (int i = hit_at; i < list_len - 1; i++) list_words[i] = list_words[i + 1];
          list_len--;
        end
      end
    end
    res.cnt = CNT_OUT_W'(list_len);
    return res;
  endfunction

  function automatic dir_row_t row(input logic [REQ_W-1:0] kind,
                                   input logic [VALUE_W-1:0] value, input bit typed,
                                   input logic [STAT_W-1:0] st, input logic fnd,
                                   input logic [POS_OUT_W-1:0] pos,
                                   input logic [CNT_OUT_W-1:0] cnt);
    dir_row_t r;
    r.kind        = kind;
    r.value       = value;
    r.typed       = typed;
    r.want.status = st;
    r.want.found  = fnd;
    r.want.pos    = pos;
    r.want.cnt    = cnt;
    return r;
  endfunction

  // keys lean toward live entries so search and delete hit often
  function automatic logic [VALUE_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (list_len > 0 && r < 60) return list_words[$urandom_range(0, list_len - 1)];
    if (r < 80) return value_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  task automatic check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, expv, actv);
      err_cnt++;
    end
  endtask

  task automatic send_word(input logic [REQ_W-1:0] kind, input logic [VALUE_W-1:0] value,
                           input bit typed, input list_result_t want);
    in_valid_i   <= 1'b1;
    req_type_i   <= kind;
    item_value_i <= value;
    want_typed   <= typed;
    want_fixed   <= want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_sender(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // output check first, then the accepted input updates the list
  always @(posedge clk_i) begin : scoreboard
    list_result_t want, got, pred;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{status: status_o, found: found_o, pos: match_position_o,
                cnt: entry_count_o};
        if (pending_results.size() == 0) begin
          $display("%0t ns: unexpected result word %h", $time, got);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", int'(want.status), int'(got.status));
          check_field("found", int'(want.found), int'(got.found));
          check_field("match_position", int'(want.pos), int'(got.pos));
          check_field("entry_count", int'(want.cnt), int'(got.cnt));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pred = apply_request(req_type_i, item_value_i);
        pending_results.push_back(want_typed ? want_fixed : pred);
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Mismatches found");
    $finish;
  end

  // receiver: stretches of different stall patterns, plus one long hold-off
  initial begin : rx_stall
    rx_mode_e mode;
    int       span;
    wait (rst_ni);
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 120);
      repeat (span) begin
        @(negedge clk_i);
        if (hold_go) begin
          hold_go = 1'b0;
          out_stall_i <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk_i);
        end
        case (mode)
          RX_FREE:   out_stall_i <= 1'b0;
          RX_LIGHT:  out_stall_i <= ($urandom_range(0, 99) < 25);
          RX_HEAVY:  out_stall_i <= ($urandom_range(0, 99) < 70);
          default:   out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  initial begin : stimulus
    int                 burst_left;
    int                 r;
    bit                 grow;
    logic [REQ_W-1:0]   kind;
    logic [VALUE_W-1:0] value;
    list_result_t       none;

    none = '0;
    burst_left = 0;
    grow = 1'b1;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom();

    // empty list, then extremes and a duplicate, fill to full, then search and delete
    dir_rows[0]  = row(REQ_SEARCH, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, 1'b0, 4'd0, 5'd0);
    dir_rows[1]  = row(REQ_DELETE, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, 1'b0, 4'd0, 5'd0);
    dir_rows[2]  = row(REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, STAT_OK, 1'b0, 4'd0, 5'd0);
    dir_rows[3]  = row(REQ_APPEND, 32'h8000_0000, 1'b1, STAT_OK, 1'b0, 4'd0, 5'd1);
    dir_rows[4]  = row(REQ_APPEND, 32'h7FFF_FFFF, 1'b1, STAT_OK, 1'b0, 4'd0, 5'd2);
    dir_rows[5]  = row(REQ_APPEND, 32'h0000_0000, 1'b0, STAT_OK, 1'b0, 4'd0, 5'd0);
    dir_rows[6]  = row(REQ_APPEND, 32'hFFFF_FFFF, 1'b0, STAT_OK, 1'b0, 4'd0, 5'd0);
    dir_rows[7]  = row(REQ_APPEND, 32'h7FFF_FFFF, 1'b0, STAT_OK, 1'b0, 4'd0, 5'd0);
    for (int i = 0; i < 11; i++)
      dir_rows[8 + i] = row(REQ_APPEND, 32'h5A5A_0000 + i, 1'b0, STAT_OK, 1'b0, 4'd0, 5'd0);
    dir_rows[19] = row(REQ_APPEND, 32'h1234_5678, 1'b1, STAT_FULL, 1'b0, 4'd0, 5'd16);
    dir_rows[20] = row(REQ_SEARCH, 32'h7FFF_FFFF, 1'b0, STAT_OK, 1'b0, 4'd0, 5'd0);
    dir_rows[21] = row(REQ_SEARCH, 32'h5A5A_000A, 1'b1, STAT_OK, 1'b1, 4'd15, 5'd16);
    dir_rows[22] = row(REQ_DELETE, 32'h7FFF_FFFF, 1'b0, STAT_OK, 1'b0, 4'd0, 5'd0);
    dir_rows[23] = row(REQ_DELETE, 32'h8000_0000, 1'b0, STAT_OK, 1'b0, 4'd0, 5'd0);
    dir_rows[24] = row(REQ_SEARCH, 32'h1234_5678, 1'b1, STAT_NOT_FOUND, 1'b0, 4'd0, 5'd14);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    foreach (dir_rows[i])
      send_word(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
      end
      burst_left--;
      if (n == 300) hold_go = 1'b1;
      if (n == 700) begin
        idle_sender(1);
        while (pending_results.size() != 0) @(negedge clk_i);
      end
      // swing between filling and draining so the count wanders end to end
      if ($urandom_range(0, 119) == 0) grow = ~grow;
      r = $urandom_range(0, 99);
      if (r < 3)                    kind = REQ_UNUSED;
      else if (r < (grow ? 63 : 28)) kind = REQ_APPEND;
      else if (r < (grow ? 80 : 58)) kind = REQ_SEARCH;
      else                          kind = REQ_DELETE;
      if (kind == REQ_APPEND)
        value = ($urandom_range(0, 99) < 60) ? value_pool[$urandom_range(0, 7)] : $urandom();
      else if (kind == REQ_UNUSED)
        value = $urandom();
      else
        value = pick_key();
      send_word(kind, value, 1'b0, none);
    end

    idle_sender(1);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
